FILE: hw/rtl/srcr_pkg.sv
package srcr_pkg;

    // ring geometry, settled by the 3-bit slot fields
    localparam int SLOT_COUNT = 8;
    localparam int PtrW       = $clog2(SLOT_COUNT);
    localparam int CntW       = $clog2(SLOT_COUNT + 1);

    // operation codes
    localparam logic [1:0] OP_CLAIM_WR  = 2'd0;
    localparam logic [1:0] OP_RETURN_WR = 2'd1;
    localparam logic [1:0] OP_CLAIM_RD  = 2'd2;
    localparam logic [1:0] OP_RETURN_RD = 2'd3;

    // result codes
    localparam logic [1:0] RC_OK     = 2'd0;
    localparam logic [1:0] RC_NOSLOT = 2'd1;
    localparam logic [1:0] RC_WRONG  = 2'd2;

    typedef enum logic [1:0] {
        ST_FREE   = 2'd0,
        ST_INUSE  = 2'd1,
        ST_FILLED = 2'd2
    } slot_st_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] slot_index;
    } req_t;

    typedef struct packed {
        logic [2:0] granted_slot;
        logic [1:0] result_code;
    } rsp_t;

    // ring bookkeeping as seen by the decision logic
    typedef struct packed {
        logic [PtrW-1:0] wp;
        logic [PtrW-1:0] rp;
        logic [CntW-1:0] free_cnt;
        logic [CntW-1:0] filled_cnt;
    } ring_view_t;

    // state changes caused by one request
    typedef struct packed {
        logic            st_wr;
        logic [PtrW-1:0] st_slot;
        slot_st_t        st_val;
        logic            wp_adv;
        logic            rp_adv;
        logic            free_dec;
        logic            free_inc;
        logic            filled_dec;
        logic            filled_inc;
    } ring_upd_t;

endpackage

FILE: hw/rtl/srcr_decide.sv
module srcr_decide (
    input  srcr_pkg::req_t              req,
    input  srcr_pkg::ring_view_t        view,
    output logic [srcr_pkg::PtrW-1:0]   look_addr,
    input  srcr_pkg::slot_st_t          look_state,
    output srcr_pkg::rsp_t              rsp,
    output srcr_pkg::ring_upd_t         upd
);
    import srcr_pkg::*;

    logic idx_ok;

    // status lookup: the read pointer for read claims, otherwise the write pointer
    assign look_addr = (req.opcode == OP_CLAIM_RD) ? view.rp : view.wp;

    assign idx_ok = CntW'(req.slot_index) < CntW'(SLOT_COUNT);

    always_comb
    begin
        upd              = '0;
        rsp.granted_slot = '0;
        rsp.result_code  = RC_OK;
        unique case (req.opcode)
            OP_CLAIM_WR:
            begin
                if (view.free_cnt == '0)
                begin
                    rsp.result_code = RC_NOSLOT;
                end
                else if (look_state != ST_FREE)
                begin
                    rsp.result_code  = RC_WRONG;
                    rsp.granted_slot = 3'(view.wp);
                end
                else
                begin
                    rsp.granted_slot = 3'(view.wp);
                    upd.st_wr        = 1'b1;
                    upd.st_slot      = view.wp;
                    upd.st_val       = ST_INUSE;
                    upd.wp_adv       = 1'b1;
                    upd.free_dec     = 1'b1;
                end
            end
            OP_CLAIM_RD:
            begin
                if (view.filled_cnt == '0)
                begin
                    rsp.result_code = RC_NOSLOT;
                end
                else if (look_state != ST_FILLED)
                begin
                    rsp.result_code  = RC_WRONG;
                    rsp.granted_slot = 3'(view.rp);
                end
                else
                begin
                    // read pointer moves on the return, not here
                    rsp.granted_slot = 3'(view.rp);
                    upd.st_wr        = 1'b1;
                    upd.st_slot      = view.rp;
                    upd.st_val       = ST_INUSE;
                    upd.filled_dec   = 1'b1;
                end
            end
            OP_RETURN_WR:
            begin
                rsp.granted_slot = req.slot_index;
                if (!idx_ok)
                begin
                    rsp.result_code = RC_WRONG;
                end
                else
                begin
                    upd.st_wr      = 1'b1;
                    upd.st_slot    = PtrW'(req.slot_index);
                    upd.st_val     = ST_FILLED;
                    upd.filled_inc = 1'b1;
                end
            end
            OP_RETURN_RD:
            begin
                rsp.granted_slot = req.slot_index;
                if (!idx_ok)
                begin
                    rsp.result_code = RC_WRONG;
                end
                else
                begin
                    upd.st_wr    = 1'b1;
                    upd.st_slot  = PtrW'(req.slot_index);
                    upd.st_val   = ST_FREE;
                    upd.rp_adv   = 1'b1;
                    upd.free_inc = 1'b1;
                end
            end
        endcase
    end

endmodule

FILE: hw/rtl/srcr_state.sv
module srcr_state (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  srcr_pkg::ring_upd_t         upd,
    input  logic [srcr_pkg::PtrW-1:0]   look_addr,
    output srcr_pkg::slot_st_t          look_state,
    output srcr_pkg::ring_view_t        view
);
    import srcr_pkg::*;

    localparam logic [PtrW-1:0] LastPtr = PtrW'(SLOT_COUNT - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(SLOT_COUNT);

    logic [PtrW-1:0] wp_reg, wp_next;
    logic [PtrW-1:0] rp_reg, rp_next;
    logic [CntW-1:0] free_cnt_reg, free_cnt_next;
    logic [CntW-1:0] filled_cnt_reg, filled_cnt_next;
    slot_st_t        slot_st_reg  [SLOT_COUNT];
    slot_st_t        slot_st_next [SLOT_COUNT];

    assign look_state      = slot_st_reg[look_addr];
    assign view.wp         = wp_reg;
    assign view.rp         = rp_reg;
    assign view.free_cnt   = free_cnt_reg;
    assign view.filled_cnt = filled_cnt_reg;

    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        free_cnt_next   = free_cnt_reg;
        filled_cnt_next = filled_cnt_reg;
        slot_st_next    = slot_st_reg;
        if (apply)
        begin
            if (upd.st_wr)
                slot_st_next[upd.st_slot] = upd.st_val;
            if (upd.wp_adv)
                wp_next = (wp_reg == LastPtr) ? '0 : wp_reg + PtrW'(1);
            if (upd.rp_adv)
                rp_next = (rp_reg == LastPtr) ? '0 : rp_reg + PtrW'(1);
            // returns saturate at the slot count
            if (upd.free_dec)
                free_cnt_next = free_cnt_reg - CntW'(1);
            else if (upd.free_inc && free_cnt_reg < FullCnt)
                free_cnt_next = free_cnt_reg + CntW'(1);
            if (upd.filled_dec)
                filled_cnt_next = filled_cnt_reg - CntW'(1);
            else if (upd.filled_inc && filled_cnt_reg < FullCnt)
                filled_cnt_next = filled_cnt_reg + CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            rp_reg         <= '0;
            free_cnt_reg   <= FullCnt;
            filled_cnt_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_st_reg[i] <= ST_FREE;
        end
        else
        begin
            wp_reg         <= wp_next;
            rp_reg         <= rp_next;
            free_cnt_reg   <= free_cnt_next;
            filled_cnt_reg <= filled_cnt_next;
            slot_st_reg    <= slot_st_next;
        end
    end

endmodule

FILE: hw/rtl/slot_ring_claim_return.sv
// slot ring claim/return manager: eight buffer slots shared by one producer
// and one consumer; each request claims or returns a write or read slot
// request channel: request_valid / request_ready carry opcode and slot_index
// response channel: response_valid / response_ready carry granted_slot and
//   result_code (ok, no slot, wrong state), exactly one response per request
// a taken request waits in the input register until the response register is
//   empty or draining, and its response is then registered there
// throughput: one request per cycle while the response channel is free;
//   path: input register, status lookup and count update, response register
// a request sees the ring state left by every earlier request
// claims never wait: an empty count answers at once with no slot
// reset: pointers zero, free count eight, filled count zero, all slots free,
//   both channel registers empty
// receiver stall: the response register holds its response; one more request
//   is still taken into the input register, after which request_ready drops
//   until the response is taken
module slot_ring_claim_return (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             request_valid,
    output logic             request_ready,
    input  srcr_pkg::req_t   request,
    output logic             response_valid,
    input  logic             response_ready,
    output srcr_pkg::rsp_t   response
);
    import srcr_pkg::*;

    logic       in_valid_reg, in_valid_next;
    req_t       in_req_reg;
    logic       out_valid_reg, out_valid_next;
    rsp_t       out_rsp_reg;

    logic       advance;
    logic       take;
    ring_view_t view;
    ring_upd_t  upd;
    rsp_t       rsp;
    logic [PtrW-1:0] look_addr;
    slot_st_t   look_state;

    // the held request moves on when the response register is empty or draining
    assign advance       = in_valid_reg && (!out_valid_reg || response_ready);
    assign request_ready = !in_valid_reg || advance;
    assign take          = request_valid && request_ready;

    assign response_valid = out_valid_reg;
    assign response       = out_rsp_reg;

    srcr_decide u_decide (
        .req        (in_req_reg),
        .view       (view),
        .look_addr  (look_addr),
        .look_state (look_state),
        .rsp        (rsp),
        .upd        (upd)
    );

    // state commits in the same edge as the response is registered
    srcr_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .apply      (advance),
        .upd        (upd),
        .look_addr  (look_addr),
        .look_state (look_state),
        .view       (view)
    );

    always_comb
    begin
        in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (response_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            in_req_reg <= request;
        if (advance)
            out_rsp_reg <= rsp;
    end

endmodule

FILE: hw/rtl/srcr_checker.sv
module srcr_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             request_ready,
    input  logic             response_valid,
    input  logic             response_ready,
    input  srcr_pkg::rsp_t   response
);
    import srcr_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && !response_ready |=> response_valid && $stable(response))
        else $error("response changed while stalled");

    // back-pressure only comes from a waiting response
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !request_ready |-> response_valid && !response_ready)
        else $error("request_ready low without a stalled response");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        response_valid |-> response.result_code == RC_OK ||
            response.result_code == RC_NOSLOT || response.result_code == RC_WRONG)
        else $error("undefined result code");

    a_noslot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        response_valid && response.result_code == RC_NOSLOT |->
            response.granted_slot == '0)
        else $error("no-slot response with non-zero slot");

endmodule

bind slot_ring_claim_return srcr_checker u_srcr_checker (.*);
